/* rtl/bsc_pkg.sv */
// Shared types, constants and float helpers for the bidiagonal Sturm count block.
package bsc_pkg;

    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_ADD = 2'd1,
        OP_SUB = 2'd2,
        OP_DIV = 2'd3
    } fpu_op_t;

    typedef struct packed {
        logic    start;
        fpu_op_t op;
    } fpu_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } fpu_rsp_t;

    localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
    localparam logic [31:0] FP_ZERO = 32'h0000_0000;
    localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;

    function automatic logic fp_is_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic fp_is_inf(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    endfunction

    function automatic logic fp_is_zero(input logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    function automatic logic fp_is_neg(input logic [31:0] x);
        return x[31] && !fp_is_zero(x) && !fp_is_nan(x);
    endfunction

endpackage

/* rtl/bsc_fpu.sv */
// Shared single-precision multiply, add, subtract and divide unit.
module bsc_fpu
(
    input  logic             clk,
    input  logic             rst_n,
    input  bsc_pkg::fpu_req_t req,
    input  logic [31:0]      opa,
    input  logic [31:0]      opb,
    output bsc_pkg::fpu_rsp_t rsp
);
    import bsc_pkg::*;

    typedef enum logic [6:0] {
        F_IDLE = 7'b000_0001,
        F_PRE  = 7'b000_0010,
        F_CALC = 7'b000_0100,
        F_DIV  = 7'b000_1000,
        F_NORM = 7'b001_0000,
        F_RND  = 7'b010_0000,
        F_DONE = 7'b100_0000
    } fstate_t;

    fstate_t            state_reg, state_next;
    fpu_op_t            op_reg;
    logic               sa_reg, sb_reg, sr_reg;
    logic [23:0]        ma_reg, mb_reg;
    logic signed [10:0] ea_reg, eb_reg, e_reg;
    logic [47:0]        acc_reg;
    logic [24:0]        rem_reg;
    logic [4:0]         cnt_reg;
    logic [31:0]        res_reg;

    logic        sb_in, spec;
    logic [31:0] spec_val;

    function automatic logic signed [10:0] unp_exp(input logic [7:0] ef);
        return (ef == 8'd0) ? -11'sd149 : $signed({3'b000, ef}) - 11'sd150;
    endfunction

    always_comb
    begin
        sb_in    = opb[31] ^ (req.op == OP_SUB);
        spec     = 1'b1;
        spec_val = FP_QNAN;
        unique case (req.op)
            OP_MUL:
            begin
                if (fp_is_nan(opa) || fp_is_nan(opb) || (fp_is_inf(opa) && fp_is_zero(opb))
                    || (fp_is_zero(opa) && fp_is_inf(opb)))
                    spec_val = FP_QNAN;
                else if (fp_is_inf(opa) || fp_is_inf(opb))
                    spec_val = {opa[31] ^ sb_in, 8'hFF, 23'd0};
                else if (fp_is_zero(opa) || fp_is_zero(opb))
                    spec_val = {opa[31] ^ sb_in, 31'd0};
                else
                    spec = 1'b0;
            end
            OP_DIV:
            begin
                if (fp_is_nan(opa) || fp_is_nan(opb) || (fp_is_zero(opa) && fp_is_zero(opb))
                    || (fp_is_inf(opa) && fp_is_inf(opb)))
                    spec_val = FP_QNAN;
                else if (fp_is_zero(opb) || fp_is_inf(opa))
                    spec_val = {opa[31] ^ sb_in, 8'hFF, 23'd0};
                else if (fp_is_inf(opb) || fp_is_zero(opa))
                    spec_val = {opa[31] ^ sb_in, 31'd0};
                else
                    spec = 1'b0;
            end
            default:
            begin
                if (fp_is_nan(opa) || fp_is_nan(opb)
                    || (fp_is_inf(opa) && fp_is_inf(opb) && (opa[31] != sb_in)))
                    spec_val = FP_QNAN;
                else if (fp_is_inf(opa))
                    spec_val = opa;
                else if (fp_is_inf(opb))
                    spec_val = {sb_in, opb[30:0]};
                else if (fp_is_zero(opa) && fp_is_zero(opb))
                    spec_val = {opa[31] & sb_in, 31'd0};
                else if (fp_is_zero(opa))
                    spec_val = {sb_in, opb[30:0]};
                else if (fp_is_zero(opb))
                    spec_val = opa;
                else
                    spec = 1'b0;
            end
        endcase
    end

    // alignment add
    logic               swap, eff_sub, sx;
    logic [23:0]        mx, my;
    logic signed [10:0] ex, ey, dexp;
    logic [26:0]        my_ext, ys;
    logic [27:0]        sum;

    always_comb
    begin
        swap    = (eb_reg > ea_reg) || ((eb_reg == ea_reg) && (mb_reg > ma_reg));
        mx      = swap ? mb_reg : ma_reg;
        my      = swap ? ma_reg : mb_reg;
        ex      = swap ? eb_reg : ea_reg;
        ey      = swap ? ea_reg : eb_reg;
        sx      = swap ? sb_reg : sa_reg;
        eff_sub = sa_reg ^ sb_reg;
        dexp    = ex - ey;
        my_ext  = {my, 3'b000};
        if (dexp >= 11'sd27)
            ys = 27'd1;
        else
            ys = (my_ext >> dexp[4:0])
                 | {26'd0, |(my_ext & ~({27{1'b1}} << dexp[4:0]))};
        if (eff_sub)
            sum = {1'b0, mx, 3'b000} - {1'b0, ys};
        else
            sum = {1'b0, mx, 3'b000} + {1'b0, ys};
    end

    // restoring divide step
    logic        q_bit;
    logic [24:0] rem_sub;

    always_comb
    begin
        q_bit   = rem_reg >= {1'b0, mb_reg};
        rem_sub = q_bit ? (rem_reg - {1'b0, mb_reg}) : rem_reg;
    end

    // round and pack
    logic signed [10:0] be, sh;
    logic [25:0]        m26, mr;
    logic [7:0]         base;
    logic [24:0]        r25;
    logic [31:0]        mag, rnd_val;

    always_comb
    begin
        be   = e_reg + 11'sd174;
        sh   = 11'sd1 - be;
        m26  = {acc_reg[47:23], |acc_reg[22:0]};
        base = 8'd0;
        mr   = m26;
        if (be >= 11'sd1)
            base = 8'(be - 11'sd1);
        else if (sh > 11'sd26)
            mr = 26'd1;
        else
            mr = (m26 >> sh[4:0]) | {25'd0, |(m26 & ~({26{1'b1}} << sh[4:0]))};
        r25 = {1'b0, mr[25:2]} + {24'd0, mr[1] & (mr[0] | mr[2])};
        mag = {1'b0, base, 23'd0} + {7'd0, r25};
        if (be >= 11'sd255)
            rnd_val = {sr_reg, 8'hFF, 23'd0};
        else
            rnd_val = {sr_reg, mag[30:0]};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (req.start) state_next = spec ? F_DONE : F_PRE;
            F_PRE:  if (ma_reg[23] && mb_reg[23]) state_next = F_CALC;
            F_CALC:
            begin
                if (op_reg == OP_DIV)
                    state_next = F_DIV;
                else if ((op_reg != OP_MUL) && (sum == 28'd0))
                    state_next = F_DONE;
                else
                    state_next = F_NORM;
            end
            F_DIV:  if (cnt_reg == 5'd26) state_next = F_NORM;
            F_NORM: if (acc_reg[47]) state_next = F_RND;
            F_RND:  state_next = F_DONE;
            F_DONE: state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            F_IDLE:
            begin
                if (req.start)
                begin
                    op_reg  <= req.op;
                    sa_reg  <= opa[31];
                    sb_reg  <= sb_in;
                    res_reg <= spec_val;
                    ma_reg  <= {opa[30:23] != 8'd0, opa[22:0]};
                    mb_reg  <= {opb[30:23] != 8'd0, opb[22:0]};
                    ea_reg  <= unp_exp(opa[30:23]);
                    eb_reg  <= unp_exp(opb[30:23]);
                end
            end
            F_PRE:
            begin
                if (!ma_reg[23])
                begin
                    if (ma_reg[23:16] == 8'd0)
                    begin
                        ma_reg <= ma_reg << 8;
                        ea_reg <= ea_reg - 11'sd8;
                    end
                    else
                    begin
                        ma_reg <= ma_reg << 1;
                        ea_reg <= ea_reg - 11'sd1;
                    end
                end
                if (!mb_reg[23])
                begin
                    if (mb_reg[23:16] == 8'd0)
                    begin
                        mb_reg <= mb_reg << 8;
                        eb_reg <= eb_reg - 11'sd8;
                    end
                    else
                    begin
                        mb_reg <= mb_reg << 1;
                        eb_reg <= eb_reg - 11'sd1;
                    end
                end
            end
            F_CALC:
            begin
                unique case (op_reg)
                    OP_MUL:
                    begin
                        acc_reg <= ma_reg * mb_reg;
                        e_reg   <= ea_reg + eb_reg;
                        sr_reg  <= sa_reg ^ sb_reg;
                    end
                    OP_DIV:
                    begin
                        acc_reg <= 48'd0;
                        rem_reg <= {1'b0, ma_reg};
                        cnt_reg <= 5'd0;
                        e_reg   <= ea_reg - eb_reg - 11'sd47;
                        sr_reg  <= sa_reg ^ sb_reg;
                    end
                    default:
                    begin
                        acc_reg <= {sum, 20'd0};
                        e_reg   <= ex - 11'sd23;
                        sr_reg  <= sx;
                        res_reg <= FP_ZERO;
                    end
                endcase
            end
            F_DIV:
            begin
                rem_reg <= {rem_sub[23:0], 1'b0};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd26)
                    acc_reg <= {acc_reg[25:0], q_bit, rem_sub != 25'd0, 20'd0};
                else
                    acc_reg <= {acc_reg[46:0], q_bit};
            end
            F_NORM:
            begin
                if (!acc_reg[47])
                begin
                    if (acc_reg[47:40] == 8'd0)
                    begin
                        acc_reg <= acc_reg << 8;
                        e_reg   <= e_reg - 11'sd8;
                    end
                    else
                    begin
                        acc_reg <= acc_reg << 1;
                        e_reg   <= e_reg - 11'sd1;
                    end
                end
            end
            F_RND:  res_reg <= rnd_val;
            F_DONE: ;
            default: ;
        endcase
    end

    assign rsp = {state_reg == F_DONE, res_reg};

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == F_IDLE)
        else $error("start while unit busy");

    a_rnd_norm: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == F_RND |-> acc_reg[47])
        else $error("rounding an unnormalized value");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == F_DIV |=> (state_reg == F_DIV || state_reg == F_NORM))
        else $error("divide left early");

endmodule

/* rtl/bidiagonal_sturm_count.sv */
// Bidiagonal Sturm count top level: row sequencer, recurrence state and stream ports.
// Each accepted row runs seven single-precision operations (b*b, x*x, a*a, the divide by the
// pivot, t*q, the subtract and the final add) one after another on a single shared float
// unit, each rounded to nearest-even. The divide adds restoring quotient iterations. Zero,
// infinite or NaN operands finish an operation without entering the calculation states,
// while subnormal operands and deep cancellation add normalization shifts. The next row is
// accepted once the count test of the current row is done. On a row marked last the count
// is presented on the master side, and the pivot, partial term and count return to 1.0,
// +0.0 and 0; that row holds in its final step while an earlier count is still waiting on
// the master side.
module bidiagonal_sturm_count
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] diag_value, [63:32] offdiag_value
    input  logic        s_tlast,   // last_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [12:0] below_count, [15:13] zero
    input  logic        cfg_wen,
    input  logic [31:0] cfg_wdata  // shift_value
);
    import bsc_pkg::*;

    typedef enum logic [3:0] {
        T_IDLE  = 4'b0001,
        T_ISSUE = 4'b0010,
        T_WAIT  = 4'b0100,
        T_FIN   = 4'b1000
    } tstate_t;

    typedef enum logic [6:0] {
        ST_BB = 7'b000_0001,
        ST_XX = 7'b000_0010,
        ST_AA = 7'b000_0100,
        ST_Q  = 7'b000_1000,
        ST_TQ = 7'b001_0000,
        ST_T  = 7'b010_0000,
        ST_D  = 7'b100_0000
    } step_t;

    localparam logic [12:0] COUNT_MAX = 13'h1FFF;

    tstate_t     state_reg;
    step_t       step_reg;
    logic [31:0] shift_reg, d_reg, t_reg, tmp_reg, xx_reg, aa_reg, diag_reg, off_reg;
    logic        last_reg;
    logic [12:0] cnt_reg, cnt_next, out_reg;
    logic        mval_reg;

    fpu_req_t    req;
    fpu_rsp_t    rsp;
    logic [31:0] opa, opb;
    logic        out_free;

    assign s_tready = state_reg == T_IDLE;
    assign m_tvalid = mval_reg;
    assign m_tdata  = {3'b000, out_reg};
    assign out_free = !mval_reg || m_tready;

    always_comb
    begin
        req.start = state_reg == T_ISSUE;
        req.op    = OP_MUL;
        opa       = off_reg;
        opb       = off_reg;
        unique case (step_reg)
            ST_BB: begin req.op = OP_MUL; opa = off_reg;   opb = off_reg;   end
            ST_XX: begin req.op = OP_MUL; opa = shift_reg; opb = shift_reg; end
            ST_AA: begin req.op = OP_MUL; opa = diag_reg;  opb = diag_reg;  end
            ST_Q:  begin req.op = OP_DIV; opa = tmp_reg;   opb = d_reg;     end
            ST_TQ: begin req.op = OP_MUL; opa = t_reg;     opb = tmp_reg;   end
            ST_T:  begin req.op = OP_SUB; opa = tmp_reg;   opb = xx_reg;    end
            ST_D:  begin req.op = OP_ADD; opa = aa_reg;    opb = t_reg;     end
            default: ;
        endcase
    end

    bsc_fpu u_fpu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .opa   (opa),
        .opb   (opb),
        .rsp   (rsp)
    );

    assign cnt_next = (fp_is_neg(d_reg) && (cnt_reg < COUNT_MAX)) ? cnt_reg + 13'd1 : cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            step_reg  <= ST_BB;
            shift_reg <= FP_ZERO;
            d_reg     <= FP_ONE;
            t_reg     <= FP_ZERO;
            cnt_reg   <= 13'd0;
            mval_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
                shift_reg <= cfg_wdata;
            if (state_reg == T_FIN && last_reg && out_free)
                mval_reg <= 1'b1;
            else if (mval_reg && m_tready)
                mval_reg <= 1'b0;
            unique case (state_reg)
                T_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        step_reg  <= ST_BB;
                        state_reg <= T_ISSUE;
                    end
                end
                T_ISSUE: state_reg <= T_WAIT;
                T_WAIT:
                begin
                    if (rsp.done)
                    begin
                        unique case (step_reg)
                            ST_BB: step_reg <= ST_XX;
                            ST_XX: step_reg <= ST_AA;
                            ST_AA: step_reg <= ST_Q;
                            ST_Q:  step_reg <= ST_TQ;
                            ST_TQ: step_reg <= ST_T;
                            ST_T:  step_reg <= ST_D;
                            ST_D:  step_reg <= ST_BB;
                            default: step_reg <= ST_BB;
                        endcase
                        if (step_reg == ST_T)
                            t_reg <= rsp.result;
                        if (step_reg == ST_D)
                        begin
                            d_reg     <= rsp.result;
                            state_reg <= T_FIN;
                        end
                        else
                            state_reg <= T_ISSUE;
                    end
                end
                T_FIN:
                begin
                    if (!last_reg)
                    begin
                        cnt_reg   <= cnt_next;
                        state_reg <= T_IDLE;
                    end
                    else if (out_free)
                    begin
                        d_reg     <= FP_ONE;
                        t_reg     <= FP_ZERO;
                        cnt_reg   <= 13'd0;
                        state_reg <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            diag_reg <= s_tdata[31:0];
            off_reg  <= s_tdata[63:32];
            last_reg <= s_tlast;
        end
        if (state_reg == T_FIN && last_reg && out_free)
            out_reg <= cnt_next;
        if (state_reg == T_WAIT && rsp.done)
        begin
            unique case (step_reg)
                ST_XX: xx_reg  <= rsp.result;
                ST_AA: aa_reg  <= rsp.result;
                ST_BB, ST_Q, ST_TQ: tmp_reg <= rsp.result;
                default: ;
            endcase
        end
    end

    a_one_row: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second row accepted while busy");

    a_out_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(last_reg) && $past(state_reg) == T_FIN))
        else $error("result without a last row");

    a_start_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> !req.start)
        else $error("back to back start");

endmodule
